FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the allocation tracker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ATT_ASSERT_IMPLY(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication, reset masks the check
`define ATT_ASSERT_NEXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

FILE: src/att_pkg.sv
// ---------------------------------------------------------------------------
// att_pkg
// Types, codes and default sizes shared by the allocation tracker files.
// ---------------------------------------------------------------------------
package att_pkg;

  // default sizes
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int BANK_COUNT_DEF  = 8;
  localparam int LOG_DEPTH_DEF   = 128;

  // operation kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_BANK  = 2'd2;
  localparam logic [1:0] KIND_LOG   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BANK     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_LOGGED   = 3'd3;
  localparam logic [2:0] ST_UNLOGGED = 3'd4;
  localparam logic [2:0] ST_INDEX    = 3'd5;

  // one table entry held in a cell
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [7:0]  bank;
    logic [31:0] size;
  } cell_t;

  // search beat travelling down the chain
  typedef struct packed {
    logic        vld;
    logic        found;
    logic [7:0]  bank;
    logic [31:0] size;
  } pkt_t;

endpackage

FILE: src/att_ram.sv
// ---------------------------------------------------------------------------
// att_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module att_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/att_cell.sv
// ---------------------------------------------------------------------------
// att_cell
// One table cell: holds an entry, checks the passing search beat and
// shifts down from its neighbor once the matching entry has been removed.
// ---------------------------------------------------------------------------
module att_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           we,
  input  att_pkg::cell_t wr,
  input  logic [31:0]    scan_addr,
  input  att_pkg::pkt_t  pk_in,
  output att_pkg::pkt_t  pk_out,
  input  logic           pull,
  input  att_pkg::cell_t nxt,
  output att_pkg::cell_t cur
);
  import att_pkg::*;

  logic        valid;
  logic [31:0] addr;
  logic [7:0]  bank;
  logic [31:0] size;
  logic        hit;
  logic        kill;

  // earliest match only: beat not yet satisfied
  assign hit  = pk_in.vld && !pk_in.found && valid && (addr == scan_addr);
  assign kill = pk_in.vld && (pk_in.found || hit);
  assign cur  = '{valid: valid, addr: addr, bank: bank, size: size};

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (we) begin
      valid <= 1'b1;
    end else if (pull) begin
      valid <= nxt.valid;
    end else if (kill) begin
      valid <= 1'b0;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (we) begin
      addr <= wr.addr;
      bank <= wr.bank;
      size <= wr.size;
    end else if (pull) begin
      addr <= nxt.addr;
      bank <= nxt.bank;
      size <= nxt.size;
    end
  end

  // hand the search beat on
  always_ff @(posedge clk) begin
    if (rst) begin
      pk_out <= '0;
    end else begin
      pk_out.vld   <= pk_in.vld;
      pk_out.found <= pk_in.found || hit;
      pk_out.bank  <= hit ? bank : pk_in.bank;
      pk_out.size  <= hit ? size : pk_in.size;
    end
  end

endmodule

FILE: src/allocation_tracker_table.sv
// Allocate and bank query pass S_BREQ, S_BUSE; log read S_LREQ, S_LUSE; free
// scans in S_SCAN (the search beat walks the whole cell chain, one cell a cycle),
// then on a match S_BREQ, S_BUSE; errors found at accept answer from S_IDLE.
// One item at a time: busy is high meanwhile. Result beat lasts one cycle on done.
// Reset (rst, synchronous) empties the table, totals, flags and log at once.
// ---------------------------------------------------------------------------
// allocation_tracker_table
// Live allocation table built as a chain of cells, with per-bank byte totals
// and a bounded log of unmatched frees.
// ---------------------------------------------------------------------------
module allocation_tracker_table #(
  parameter int TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF,
  parameter int BANK_COUNT  = att_pkg::BANK_COUNT_DEF,
  parameter int LOG_DEPTH   = att_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] address,
  input  logic [7:0]  bank,
  input  logic [31:0] byte_size,
  input  logic [15:0] site_id,
  input  logic [19:0] site_line,
  input  logic [6:0]  log_index,
  output logic        done,
  output logic        ok,
  output logic [2:0]  status,
  output logic signed [31:0] balance,
  output logic [8:0]  live_count,
  output logic        empty_flag,
  output logic        overflow_flag,
  output logic [7:0]  error_count,
  output logic [39:0] bank_bytes,
  output logic [15:0] log_site,
  output logic [19:0] log_line
);
  import att_pkg::*;

  localparam int LW   = $clog2(TABLE_DEPTH + 1);
  localparam int BW   = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int LAW  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CW   = $clog2(LOG_DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BREQ = 3'd1;
  localparam logic [2:0] S_BUSE = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_LREQ = 3'd4;
  localparam logic [2:0] S_LUSE = 3'd5;

  logic [2:0]    state;
  logic [LW-1:0] live;
  logic [CW-1:0] log_cnt;
  logic [31:0]   bal;
  logic          empty_f;
  logic          ovf_f;
  logic          inj_vld;
  logic [BANK_COUNT-1:0] bvalid;

  logic [1:0]  kind_q;
  logic [31:0] addr_q;
  logic [7:0]  bank_q;
  logic [31:0] size_q;
  logic [15:0] site_q;
  logic [19:0] line_q;
  logic [6:0]  idx_q;

  logic        ok_q;
  logic [2:0]  status_q;
  logic [39:0] bytes_q;
  logic [15:0] lsite_q;
  logic [19:0] lline_q;

  logic          accept;
  logic          bank_bad;
  logic          full;
  logic          idx_ok;
  logic          log_ok;
  logic          alloc_we;
  logic [BW-1:0] bank_sel;
  logic [39:0]   b_rd;
  logic [39:0]   base;
  logic [39:0]   b_wdata;
  logic          b_we;
  logic [35:0]   l_rd;
  logic          l_we;
  logic [CMPW-1:0] idx_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] idx_q_ext;
  logic [LAW-1:0]  l_raddr;
  logic [31:0]   live_w;
  logic [31:0]   cnt_w;
  cell_t         wr_entry;
  pkt_t          scan_end;

  pkt_t  pk [0:TABLE_DEPTH];
  cell_t cd [0:TABLE_DEPTH];

  // decode of the incoming beat
  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign bank_bad = (bank >= 8'(BANK_COUNT));
  assign full     = (live == LW'(TABLE_DEPTH));
  assign idx_ext  = CMPW'(log_index);
  assign cnt_ext  = CMPW'(log_cnt);
  assign idx_ok   = (idx_ext < cnt_ext);
  assign log_ok   = !ovf_f && (live != '0) && (log_cnt != CW'(LOG_DEPTH));
  assign alloc_we = (state == S_IDLE) && start && (kind == KIND_ALLOC) &&
                    !bank_bad && !full;
  assign wr_entry = '{valid: 1'b1, addr: address, bank: bank, size: byte_size};

  // cell chain; the search beat enters at cell 0
  assign pk[0]           = '{vld: inj_vld, found: 1'b0, bank: 8'd0, size: 32'd0};
  assign cd[TABLE_DEPTH] = '0;
  assign scan_end        = pk[TABLE_DEPTH];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    att_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .we        (alloc_we && (live == LW'(i))),
      .wr        (wr_entry),
      .scan_addr (addr_q),
      .pk_in     (pk[i]),
      .pk_out    (pk[i+1]),
      .pull      (pk[i+1].vld && pk[i+1].found),
      .nxt       (cd[i+1]),
      .cur       (cd[i])
    );
  end

  // bank totals: read-modify-write, valid bits stand for the zero reset
  assign bank_sel = bank_q[BW-1:0];
  assign base     = bvalid[bank_sel] ? b_rd : 40'd0;
  assign b_wdata  = (kind_q == KIND_ALLOC) ? (base + {8'd0, size_q})
                                           : (base - {8'd0, size_q});
  assign b_we     = (state == S_BUSE) && (kind_q != KIND_BANK);

  att_ram #(.WIDTH(40), .DEPTH(BANK_COUNT)) u_bank_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (bank_sel),
    .wdata (b_wdata),
    .raddr (bank_sel),
    .rdata (b_rd)
  );

  // error log, filled in order, guarded by the fill count
  assign l_we      = (state == S_SCAN) && scan_end.vld && !scan_end.found && log_ok;
  assign idx_q_ext = CMPW'(idx_q);
  assign l_raddr   = (idx_q_ext < CMPW'(LOG_DEPTH)) ? idx_q_ext[LAW-1:0] : '0;

  att_ram #(.WIDTH(36), .DEPTH(LOG_DEPTH)) u_log_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (log_cnt[LAW-1:0]),
    .wdata ({site_q, line_q}),
    .raddr (l_raddr),
    .rdata (l_rd)
  );

  // sequencer and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      live    <= '0;
      log_cnt <= '0;
      bal     <= '0;
      empty_f <= 1'b0;
      ovf_f   <= 1'b0;
      inj_vld <= 1'b0;
      bvalid  <= '0;
      done    <= 1'b0;
    end else begin
      done    <= 1'b0;
      inj_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (kind)
              KIND_ALLOC: begin
                bal <= bal + 32'd1;
                if (bank_bad) begin
                  done <= 1'b1;
                end else if (full) begin
                  empty_f <= 1'b1;
                  ovf_f   <= 1'b1;
                  done    <= 1'b1;
                end else begin
                  live  <= live + LW'(1);
                  state <= S_BREQ;
                end
              end
              KIND_FREE: begin
                bal     <= bal - 32'd1;
                inj_vld <= 1'b1;
                state   <= S_SCAN;
              end
              KIND_BANK: begin
                if (bank_bad) begin
                  done <= 1'b1;
                end else begin
                  state <= S_BREQ;
                end
              end
              default: begin
                if (idx_ok) begin
                  state <= S_LREQ;
                end else begin
                  done <= 1'b1;
                end
              end
            endcase
          end
        end
        S_BREQ: state <= S_BUSE;
        S_BUSE: begin
          if (kind_q != KIND_BANK) begin
            bvalid[bank_sel] <= 1'b1;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_end.vld) begin
            if (scan_end.found) begin
              live    <= live - LW'(1);
              empty_f <= 1'b0;
              state   <= S_BREQ;
            end else begin
              if (log_ok) begin
                log_cnt <= log_cnt + CW'(1);
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_LREQ: state <= S_LUSE;
        S_LUSE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // operand capture and result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      addr_q <= address;
      bank_q <= bank;
      size_q <= byte_size;
      site_q <= site_id;
      line_q <= site_line;
      idx_q  <= log_index;
    end
    case (state)
      S_IDLE: begin
        ok_q    <= 1'b0;
        bytes_q <= 40'd0;
        lsite_q <= 16'd0;
        lline_q <= 20'd0;
        case (kind)
          KIND_ALLOC: status_q <= bank_bad ? ST_BANK : ST_FULL;
          KIND_BANK:  status_q <= ST_BANK;
          default:    status_q <= ST_INDEX;
        endcase
      end
      S_SCAN: begin
        if (scan_end.vld) begin
          if (scan_end.found) begin
            bank_q <= scan_end.bank;
            size_q <= scan_end.size;
          end
          ok_q     <= 1'b0;
          status_q <= log_ok ? ST_LOGGED : ST_UNLOGGED;
          bytes_q  <= 40'd0;
          lsite_q  <= 16'd0;
          lline_q  <= 20'd0;
        end
      end
      S_BUSE: begin
        ok_q     <= 1'b1;
        status_q <= ST_OK;
        bytes_q  <= (kind_q == KIND_BANK) ? base : 40'd0;
        lsite_q  <= 16'd0;
        lline_q  <= 20'd0;
      end
      S_LUSE: begin
        ok_q     <= 1'b1;
        status_q <= ST_OK;
        bytes_q  <= 40'd0;
        lsite_q  <= l_rd[35:20];
        lline_q  <= l_rd[19:0];
      end
      default: begin
      end
    endcase
  end

  // outputs
  assign live_w        = 32'(live);
  assign cnt_w         = 32'(log_cnt);
  assign ok            = ok_q;
  assign status        = status_q;
  assign balance       = bal;
  assign live_count    = live_w[8:0];
  assign empty_flag    = empty_f;
  assign overflow_flag = ovf_f;
  assign error_count   = cnt_w[7:0];
  assign bank_bytes    = bytes_q;
  assign log_site      = lsite_q;
  assign log_line      = lline_q;

endmodule

FILE: src/att_checker.sv
// ---------------------------------------------------------------------------
// att_checker
// Port-level checks on the allocation tracker result beats, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module att_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        ok,
  input logic [2:0]  status,
  input logic        overflow_flag,
  input logic [39:0] bank_bytes,
  input logic [19:0] log_line
);
  import att_pkg::*;

  // every result beat follows an accepted beat or a busy stretch
  `ATT_ASSERT_NEXT(a_no_phantom, clk, rst, !(start && !busy) && !busy, !done)
  // ok agrees with status
  `ATT_ASSERT_IMPLY(a_ok_status, clk, rst, done, (ok == (status == ST_OK)))
  // payload only with a good result
  `ATT_ASSERT_IMPLY(a_bytes_ok, clk, rst, done && (bank_bytes != 40'd0), ok)
  `ATT_ASSERT_IMPLY(a_line_ok, clk, rst, done && (log_line != 20'd0), ok)
  // overflow stays set until reset
  `ATT_ASSERT_NEXT(a_ovf_sticky, clk, rst, overflow_flag, overflow_flag)

endmodule

bind allocation_tracker_table att_checker u_att_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .ok            (ok),
  .status        (status),
  .overflow_flag (overflow_flag),
  .bank_bytes    (bank_bytes),
  .log_line      (log_line)
);

FILE: verif/tb_allocation_tracker_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_allocation_tracker_table
// Self-checking bench for the allocation tracker. A predictor keeps its own
// copy of the table, bank totals, flags and error log. It works out the
// expected answer for every accepted command. A monitor compares each done
// beat field by field against the oldest expectation.
// ---------------------------------------------------------------------------
module tb_allocation_tracker_table;
  import att_pkg::*;

  localparam int DEPTH  = TABLE_DEPTH_DEF;
  localparam int NBANK  = BANK_COUNT_DEF;
  localparam int LDEPTH = LOG_DEPTH_DEF;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  bank;
    logic [31:0] byte_size;
    logic [15:0] site_id;
    logic [19:0] site_line;
    logic [6:0]  log_index;
    logic        drain;     // hold off until every answer is back
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [31:0] balance;
    logic [8:0]  live_count;
    logic        empty_flag;
    logic        overflow_flag;
    logic [7:0]  error_count;
    logic [39:0] bank_bytes;
    logic [15:0] log_site;
    logic [19:0] log_line;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0]  kind = KIND_ALLOC;
  logic [31:0] address = '0;
  logic [7:0]  bank = '0;
  logic [31:0] byte_size = '0;
  logic [15:0] site_id = '0;
  logic [19:0] site_line = '0;
  logic [6:0]  log_index = '0;
  logic done, ok, empty_flag, overflow_flag;
  logic [2:0]  status;
  logic signed [31:0] balance;
  logic [8:0]  live_count;
  logic [7:0]  error_count;
  logic [39:0] bank_bytes;
  logic [15:0] log_site;
  logic [19:0] log_line;

  allocation_tracker_table i_dut (.*);

  // predictor state
  logic        tbl_valid [DEPTH];
  logic [31:0] tbl_addr  [DEPTH];
  logic [7:0]  tbl_bank  [DEPTH];
  logic [31:0] tbl_size  [DEPTH];
  int unsigned tbl_rank  [DEPTH];
  int unsigned next_rank, live_n, log_n;
  logic [31:0] bal;
  logic        flg_empty, flg_ovf;
  logic [39:0] bank_sum [NBANK];
  logic [15:0] err_site [LDEPTH];
  logic [19:0] err_line [LDEPTH];

  cmd_t    pending_cmds[$];
  answer_t expected_answers[$];
  logic [31:0] used_addrs[$];
  int  mismatches = 0;
  logic stim_done = 1'b0;
  longint cycles = 0;

  // Advance the predicted state by one command and return its answer.
  function automatic answer_t predict_answer(cmd_t c);
    answer_t a;
    int slot, hit;
    a = '0;
    case (c.kind)
      KIND_ALLOC: begin
        bal = bal + 1;
        if (c.bank >= NBANK) begin
          a.status = ST_BANK;
        end else begin
          slot = -1;
          for (int i = 0; i < DEPTH; i++)
            if (slot < 0 && !tbl_valid[i]) slot = i;
          if (slot < 0) begin
            flg_empty = 1'b1;
            flg_ovf = 1'b1;
            a.status = ST_FULL;
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_addr[slot] = c.address;
            tbl_bank[slot] = c.bank;
            tbl_size[slot] = c.byte_size;
            tbl_rank[slot] = next_rank;
            next_rank++;
            live_n++;
            bank_sum[c.bank] = bank_sum[c.bank] + 40'(c.byte_size);
            a.ok = 1'b1;
            a.status = ST_OK;
          end
        end
      end
      KIND_FREE: begin
        bal = bal - 1;
        hit = -1;
        for (int i = 0; i < DEPTH; i++)
          if (tbl_valid[i] && tbl_addr[i] == c.address &&
              (hit < 0 || tbl_rank[i] < tbl_rank[hit])) hit = i;
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_rank[i] > tbl_rank[hit]) tbl_rank[i]--;
          next_rank--;
          live_n--;
          bank_sum[tbl_bank[hit] % NBANK] = bank_sum[tbl_bank[hit] % NBANK] -
                                            40'(tbl_size[hit]);
          flg_empty = 1'b0;
          a.ok = 1'b1;
          a.status = ST_OK;
        end else if (!flg_ovf && live_n != 0 && log_n < LDEPTH) begin
          err_site[log_n] = c.site_id;
          err_line[log_n] = c.site_line;
          log_n++;
          a.status = ST_LOGGED;
        end else begin
          a.status = ST_UNLOGGED;
        end
      end
      KIND_BANK: begin
        if (c.bank >= NBANK) a.status = ST_BANK;
        else begin
          a.ok = 1'b1;
          a.bank_bytes = bank_sum[c.bank];
        end
      end
      default: begin
        if (c.log_index >= log_n) a.status = ST_INDEX;
        else begin
          a.ok = 1'b1;
          a.log_site = err_site[c.log_index];
          a.log_line = err_line[c.log_index];
        end
      end
    endcase
    a.balance = bal;
    a.live_count = 9'(live_n);
    a.empty_flag = flg_empty;
    a.overflow_flag = flg_ovf;
    a.error_count = 8'(log_n);
    return a;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  // build one command
  function automatic cmd_t make_cmd(logic [1:0] k, logic [31:0] ad, logic [7:0] bk,
                                    logic [31:0] sz, logic [6:0] li);
    cmd_t c;
    c.kind = k;
    c.address = ad;
    c.bank = bk;
    c.byte_size = sz;
    c.site_id = 16'($urandom);
    c.site_line = 20'($urandom);
    c.log_index = li;
    c.drain = 1'b0;
    return c;
  endfunction

  // address reuse makes frees hit and creates duplicates
  function automatic logic [31:0] pick_addr();
    logic [31:0] ad;
    if (used_addrs.size() > 0 && $urandom_range(0, 3) != 0)
      return used_addrs[$urandom_range(0, used_addrs.size() - 1)];
    ad = $urandom;
    used_addrs.push_back(ad);
    if (used_addrs.size() > 64) void'(used_addrs.pop_front());
    return ad;
  endfunction

  function automatic cmd_t random_cmd(int alloc_weight);
    int r;
    logic [7:0] bk;
    r = $urandom_range(0, 99);
    bk = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NBANK - 1));
    if (r < alloc_weight)
      return make_cmd(KIND_ALLOC, pick_addr(), bk, $urandom, '0);
    if (r < 80) return make_cmd(KIND_FREE, pick_addr(), bk, $urandom, '0);
    if (r < 90) return make_cmd(KIND_BANK, '0, bk, '0, '0);
    return make_cmd(KIND_LOG, '0, '0, '0, 7'($urandom));
  endfunction

  // idle percentage for the phase the sender is in
  function automatic int idle_pct(int left);
    if (left > 800) return 0;
    if (left > 500) return 46;
    if (left > 250) return 18;
    return 46;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    cmd_t c;
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    for (int b = 0; b < NBANK; b++) bank_sum[b] = '0;
    next_rank = 0; live_n = 0; log_n = 0; bal = '0;
    flg_empty = 1'b0; flg_ovf = 1'b0;
    // directed: queries on empty state, extremes, duplicates, bad banks
    pending_cmds.push_back(make_cmd(KIND_LOG, '0, '0, '0, 7'h7f));
    pending_cmds.push_back(make_cmd(KIND_BANK, '0, 8'hff, '0, '0));
    pending_cmds.push_back(make_cmd(KIND_FREE, 32'h1234, '0, '0, '0));
    pending_cmds.push_back(make_cmd(KIND_ALLOC, 32'hffff_ffff, 8'd7, 32'hffff_ffff, '0));
    pending_cmds.push_back(make_cmd(KIND_ALLOC, 32'h0, 8'd0, 32'h0, '0));
    pending_cmds.push_back(make_cmd(KIND_ALLOC, 32'hffff_ffff, 8'd7, 32'h5, '0));
    pending_cmds.push_back(make_cmd(KIND_ALLOC, 32'h0, 8'd8, 32'h7, '0));
    pending_cmds.push_back(make_cmd(KIND_ALLOC, 32'h0, 8'hff, 32'h7, '0));
    pending_cmds.push_back(make_cmd(KIND_BANK, '0, 8'd7, '0, '0));
    pending_cmds.push_back(make_cmd(KIND_FREE, 32'hdead_beef, '0, '0, '0));
    pending_cmds.push_back(make_cmd(KIND_FREE, 32'hffff_ffff, '0, '0, '0));
    pending_cmds.push_back(make_cmd(KIND_BANK, '0, 8'd7, '0, '0));
    pending_cmds.push_back(make_cmd(KIND_LOG, '0, '0, '0, 7'd0));
    pending_cmds.push_back(make_cmd(KIND_LOG, '0, '0, '0, 7'd1));
    pending_cmds.push_back(make_cmd(KIND_BANK, '0, 8'd0, '0, '0));
    pending_cmds.push_back(make_cmd(KIND_FREE, 32'h0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(KIND_FREE, 32'hffff_ffff, '0, '0, '0));
    // free with an empty table: miss must go unlogged
    pending_cmds.push_back(make_cmd(KIND_FREE, 32'h5555_aaaa, '0, '0, '0));
    c = make_cmd(KIND_BANK, '0, 8'd7, '0, '0);
    c.drain = 1'b1;
    pending_cmds.push_back(c);
    // random mix, then fill the table to overflow, then drain it
    for (int i = 0; i < 700; i++) pending_cmds.push_back(random_cmd(45));
    for (int i = 0; i < 280; i++) pending_cmds.push_back(random_cmd(95));
    c = make_cmd(KIND_LOG, '0, '0, '0, 7'd0);
    c.drain = 1'b1;
    pending_cmds.push_back(c);
    for (int i = 0; i < 120; i++) pending_cmds.push_back(random_cmd(10));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: one command per accepted beat, random idle between
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) begin
        expected_answers.push_back(predict_answer(pending_cmds.pop_front()));
      end
      if (start && busy) begin
        // hold the beat until accepted
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end else if (pending_cmds[0].drain &&
                   (expected_answers.size() != 0 || (start && !busy))) begin
        start <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct(pending_cmds.size())) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        kind <= pending_cmds[0].kind;
        address <= pending_cmds[0].address;
        bank <= pending_cmds[0].bank;
        byte_size <= pending_cmds[0].byte_size;
        site_id <= pending_cmds[0].site_id;
        site_line <= pending_cmds[0].site_line;
        log_index <= pending_cmds[0].log_index;
      end
    end
  end

  // monitor: compare each done beat with the oldest expectation
  always @(posedge clk) begin
    answer_t w;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected beat", 64'(status), 64'h0);
      end else begin
        w = expected_answers.pop_front();
        if (ok !== w.ok) report_mismatch("ok", 64'(ok), 64'(w.ok));
        if (status !== w.status) report_mismatch("status", 64'(status), 64'(w.status));
        if (balance !== w.balance) report_mismatch("balance", 64'(balance), 64'(w.balance));
        if (live_count !== w.live_count)
          report_mismatch("live_count", 64'(live_count), 64'(w.live_count));
        if (empty_flag !== w.empty_flag)
          report_mismatch("empty_flag", 64'(empty_flag), 64'(w.empty_flag));
        if (overflow_flag !== w.overflow_flag)
          report_mismatch("overflow_flag", 64'(overflow_flag), 64'(w.overflow_flag));
        if (error_count !== w.error_count)
          report_mismatch("error_count", 64'(error_count), 64'(w.error_count));
        if (bank_bytes !== w.bank_bytes)
          report_mismatch("bank_bytes", 64'(bank_bytes), 64'(w.bank_bytes));
        if (log_site !== w.log_site)
          report_mismatch("log_site", 64'(log_site), 64'(w.log_site));
        if (log_line !== w.log_line)
          report_mismatch("log_line", 64'(log_line), 64'(w.log_line));
      end
    end
  end

  // end of run: drain, settle, then verdict; cycle limit as watchdog
  initial begin
    fork
      begin
        wait (stim_done && expected_answers.size() == 0);
        repeat (DEPTH + 20) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
          $display("tb_allocation_tracker_table: clean");
        else
          $display("tb_allocation_tracker_table: errors");
      end
      begin
        wait (cycles >= CYCLE_LIMIT);
        $display("tb_allocation_tracker_table: errors");
      end
    join_any
    $finish;
  end

endmodule
